>>> hw/rtl/seg_pkg.sv
// Shared types and constants of the simplex element gradient block.
package seg_pkg;

  localparam int GRAD_W    = 32;
  localparam int ABS_DET_W = 47;
  localparam int FRAC_TRI  = 16;
  localparam int FRAC_TET  = 32;

  localparam logic [1:0] DIM_TRI = 2'd2;
  localparam logic [1:0] DIM_TET = 2'd3;

  localparam logic REG_DIMENSION = 1'b0;

  localparam logic [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0] node;
    logic       last;
    logic       tet;
  } beat_t;

  typedef struct packed {
    beat_t                  beat;
    logic                   degen;
    logic [2:0]             sat;
    logic [2:0]             neg;
    logic [ABS_DET_W-1:0]   absdet;
  } side_t;

endpackage

>>> hw/rtl/seg_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module seg_div_pipe import seg_pkg::*; #(
  parameter int DEN_W = 102,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic [DEN_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  logic [DEN_W-1:0] src_rem [Q_W];
  logic [DEN_W-1:0] src_den [Q_W];
  logic [Q_W-1:0]   src_quo [Q_W];
  logic [DEN_W:0]   r_sh    [Q_W];
  logic             ge      [Q_W];
  logic [DEN_W-1:0] rem_next [Q_W];

  always_comb begin
    src_rem[0] = num;
    src_den[0] = den;
    src_quo[0] = '0;
    for (int k = 1; k < Q_W; k++) begin
      src_rem[k] = rem_q[k-1];
      src_den[k] = den_q[k-1];
      src_quo[k] = quo_q[k-1];
    end
    for (int k = 0; k < Q_W; k++) begin
      // The remainder stays below the divisor, so the doubled value fits one extra bit.
      r_sh[k] = {src_rem[k], 1'b0};
      ge[k] = r_sh[k] >= {1'b0, src_den[k]};
      rem_next[k] = ge[k] ? DEN_W'(r_sh[k] - {1'b0, src_den[k]}) : r_sh[k][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      rem_q[k] <= rem_next[k];
      den_q[k] <= src_den[k];
      quo_q[k] <= {src_quo[k][Q_W-2:0], ge[k]};
    end
  end

  assign quo = quo_q[Q_W-1];

endmodule

>>> hw/rtl/simplex_element_gradient_top.sv
// Top level of the linear simplex shape function gradient block.
//
// One item is the node coordinates of a triangle (dimension 2) or a tetrahedron
// (dimension 3). The block captures the coordinates when it accepts an item and
// issues its three nodes (triangle) or four nodes (tetrahedron) one per cycle into a
// fixed pipeline, and busy drops during the issue of its last node so the next item
// can follow at once. An item's node results leave one per cycle with valid high, the
// last one flagged; the receiver cannot stall the block. Each result passes through
// eight arithmetic stages (products, minors and determinant), a 32-stage divider per
// gradient component and an output register. Items accepted with a dimension
// other than 2 or 3 produce no results.
module simplex_element_gradient_top import seg_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          node0_x,
  input  logic [31:0]          node0_y,
  input  logic [31:0]          node0_z,
  input  logic [31:0]          node1_x,
  input  logic [31:0]          node1_y,
  input  logic [31:0]          node1_z,
  input  logic [31:0]          node2_x,
  input  logic [31:0]          node2_y,
  input  logic [31:0]          node2_z,
  input  logic [31:0]          node3_x,
  input  logic [31:0]          node3_y,
  input  logic [31:0]          node3_z,
  output logic                 valid,
  output logic [1:0]           node_index,
  output logic [GRAD_W-1:0]    grad_x,
  output logic [GRAD_W-1:0]    grad_y,
  output logic [GRAD_W-1:0]    grad_z,
  output logic [ABS_DET_W-1:0] abs_det,
  output logic                 degenerate,
  output logic                 last_node
);

  localparam int CWE    = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int DIFF_W = CWE + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int MIN_W  = PROD_W + 1;
  localparam int LO_W   = MIN_W - DIFF_W;
  localparam int HI_W   = MIN_W - LO_W;
  localparam int PL_W   = DIFF_W + LO_W + 1;
  localparam int PH_W   = DIFF_W + HI_W;
  localparam int DET_W  = DIFF_W + MIN_W + 2;

  // Configuration port.
  logic [1:0] dimension;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIMENSION) ? {30'd0, dimension} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_TET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DIMENSION)) begin
      dimension <= pwdata[1:0];
    end
  end

  // Item capture and node issue.
  logic signed [CWE-1:0] crd [4][3];
  logic       active;
  logic [1:0] cnt;
  logic       tet;
  logic [1:0] last_cnt;
  logic       accept;
  logic       dim_ok;

  assign last_cnt = tet ? 2'd3 : 2'd2;
  assign busy     = active && (cnt != last_cnt);
  assign accept   = start && !busy;
  assign dim_ok   = (dimension == DIM_TRI) || (dimension == DIM_TET);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= 2'd0;
      tet    <= 1'b0;
    end else if (accept && dim_ok) begin
      active <= 1'b1;
      cnt    <= 2'd0;
      tet    <= (dimension == DIM_TET);
    end else if (active) begin
      if (cnt == last_cnt) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dim_ok) begin
      crd[0][0] <= node0_x[CWE-1:0];
      crd[0][1] <= node0_y[CWE-1:0];
      crd[0][2] <= node0_z[CWE-1:0];
      crd[1][0] <= node1_x[CWE-1:0];
      crd[1][1] <= node1_y[CWE-1:0];
      crd[1][2] <= node1_z[CWE-1:0];
      crd[2][0] <= node2_x[CWE-1:0];
      crd[2][1] <= node2_y[CWE-1:0];
      crd[2][2] <= node2_z[CWE-1:0];
      crd[3][0] <= node3_x[CWE-1:0];
      crd[3][1] <= node3_y[CWE-1:0];
      crd[3][2] <= node3_z[CWE-1:0];
    end
  end

  // Issue: pick the three other nodes of the current node (cyclic order).
  logic signed [CWE-1:0] sa [3];
  logic signed [CWE-1:0] sb [3];
  logic signed [CWE-1:0] sc [3];
  logic signed [CWE-1:0] sp [3];
  logic signed [CWE-1:0] sq [3];
  beat_t issue_beat;

  always_comb begin
    case (cnt)
      2'd0: begin
        sa = crd[3]; sb = crd[2]; sc = crd[1]; sp = crd[1]; sq = crd[2];
      end
      2'd1: begin
        sa = crd[0]; sb = crd[3]; sc = crd[2]; sp = crd[2]; sq = crd[0];
      end
      2'd2: begin
        sa = crd[1]; sb = crd[0]; sc = crd[3]; sp = crd[0]; sq = crd[1];
      end
      default: begin
        sa = crd[2]; sb = crd[1]; sc = crd[0]; sp = crd[0]; sq = crd[1];
      end
    endcase
    issue_beat.node = cnt;
    issue_beat.last = (cnt == last_cnt);
    issue_beat.tet  = tet;
  end

  logic [8:1] vld;

  // Stage 1: coordinate differences.
  logic signed [DIFF_W-1:0] dd1_s1 [3];
  logic signed [DIFF_W-1:0] dd2_s1 [3];
  logic signed [DIFF_W-1:0] dd3_s1 [3];
  logic signed [DIFF_W-1:0] cd1_s1 [3];
  logic signed [DIFF_W-1:0] cd2_s1 [3];
  logic signed [DIFF_W-1:0] c2x_s1, c2y_s1;
  beat_t beat_s1;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      dd1_s1[j] <= DIFF_W'(crd[1][j]) - DIFF_W'(crd[0][j]);
      dd2_s1[j] <= DIFF_W'(crd[2][j]) - DIFF_W'(crd[0][j]);
      dd3_s1[j] <= DIFF_W'(crd[3][j]) - DIFF_W'(crd[0][j]);
      cd1_s1[j] <= DIFF_W'(sb[j]) - DIFF_W'(sa[j]);
      cd2_s1[j] <= DIFF_W'(sc[j]) - DIFF_W'(sa[j]);
    end
    c2x_s1  <= DIFF_W'(sp[1]) - DIFF_W'(sq[1]);
    c2y_s1  <= DIFF_W'(sq[0]) - DIFF_W'(sp[0]);
    beat_s1 <= issue_beat;
  end

  // Stage 2: products of the minors, of the triangle determinant and of the cofactors.
  logic signed [PROD_W-1:0] mp1_s2 [3];
  logic signed [PROD_W-1:0] mp2_s2 [3];
  logic signed [PROD_W-1:0] cp1_s2 [3];
  logic signed [PROD_W-1:0] cp2_s2 [3];
  logic signed [PROD_W-1:0] tp1_s2, tp2_s2;
  logic signed [DIFF_W-1:0] abc_s2 [3];
  logic signed [DIFF_W-1:0] c2x_s2, c2y_s2;
  beat_t beat_s2;

  always_ff @(posedge clk) begin
    mp1_s2[0] <= dd2_s1[1] * dd3_s1[2];
    mp2_s2[0] <= dd2_s1[2] * dd3_s1[1];
    mp1_s2[1] <= dd2_s1[0] * dd3_s1[2];
    mp2_s2[1] <= dd2_s1[2] * dd3_s1[0];
    mp1_s2[2] <= dd2_s1[0] * dd3_s1[1];
    mp2_s2[2] <= dd2_s1[1] * dd3_s1[0];
    cp1_s2[0] <= cd1_s1[1] * cd2_s1[2];
    cp2_s2[0] <= cd2_s1[1] * cd1_s1[2];
    cp1_s2[1] <= cd1_s1[0] * cd2_s1[2];
    cp2_s2[1] <= cd2_s1[0] * cd1_s1[2];
    cp1_s2[2] <= cd1_s1[0] * cd2_s1[1];
    cp2_s2[2] <= cd2_s1[0] * cd1_s1[1];
    tp1_s2    <= dd1_s1[0] * dd2_s1[1];
    tp2_s2    <= dd2_s1[0] * dd1_s1[1];
    abc_s2    <= dd1_s1;
    c2x_s2    <= c2x_s1;
    c2y_s2    <= c2y_s1;
    beat_s2   <= beat_s1;
  end

  // Stage 3: minors, signed cofactors and the triangle determinant. The y cofactor and every odd node flip sign.
  logic signed [MIN_W-1:0]  m_s3 [3];
  logic signed [MIN_W-1:0]  cof_s3 [3];
  logic signed [MIN_W-1:0]  det2_s3;
  logic signed [DIFF_W-1:0] abc_s3 [3];
  logic signed [DIFF_W-1:0] c2x_s3, c2y_s3;
  beat_t beat_s3;
  logic flip [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      flip[j] = beat_s2.node[0] ^ (j == 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      m_s3[j]   <= MIN_W'(mp1_s2[j]) - MIN_W'(mp2_s2[j]);
      cof_s3[j] <= flip[j] ? (MIN_W'(cp2_s2[j]) - MIN_W'(cp1_s2[j]))
                           : (MIN_W'(cp1_s2[j]) - MIN_W'(cp2_s2[j]));
    end
    det2_s3 <= MIN_W'(tp1_s2) - MIN_W'(tp2_s2);
    abc_s3  <= abc_s2;
    c2x_s3  <= c2x_s2;
    c2y_s3  <= c2y_s2;
    beat_s3 <= beat_s2;
  end

  // Stage 4: the wide minor times a difference, as a high and a low partial product.
  logic signed [PH_W-1:0]  ph_s4 [3];
  logic signed [PL_W-1:0]  pl_s4 [3];
  logic signed [MIN_W-1:0] cof_s4 [3];
  logic signed [MIN_W-1:0] det2_s4;
  logic signed [DIFF_W-1:0] c2x_s4, c2y_s4;
  beat_t beat_s4;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      ph_s4[j] <= abc_s3[j] * $signed(m_s3[j][MIN_W-1:LO_W]);
      pl_s4[j] <= abc_s3[j] * $signed({1'b0, m_s3[j][LO_W-1:0]});
    end
    cof_s4  <= cof_s3;
    det2_s4 <= det2_s3;
    c2x_s4  <= c2x_s3;
    c2y_s4  <= c2y_s3;
    beat_s4 <= beat_s3;
  end

  // Stage 5: recombine the partial products.
  logic signed [DET_W-1:0] t_s5 [3];
  logic signed [MIN_W-1:0] cof_s5 [3];
  logic signed [MIN_W-1:0] det2_s5;
  logic signed [DIFF_W-1:0] c2x_s5, c2y_s5;
  beat_t beat_s5;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      t_s5[j] <= (DET_W'(ph_s4[j]) <<< LO_W) + DET_W'(pl_s4[j]);
    end
    cof_s5  <= cof_s4;
    det2_s5 <= det2_s4;
    c2x_s5  <= c2x_s4;
    c2y_s5  <= c2y_s4;
    beat_s5 <= beat_s4;
  end

  // Stage 6: tetrahedron determinant by expansion along the first row.
  logic signed [DET_W-1:0] det3_s6;
  logic signed [MIN_W-1:0] cof_s6 [3];
  logic signed [MIN_W-1:0] det2_s6;
  logic signed [DIFF_W-1:0] c2x_s6, c2y_s6;
  beat_t beat_s6;

  always_ff @(posedge clk) begin
    det3_s6 <= t_s5[0] - t_s5[1] + t_s5[2];
    cof_s6  <= cof_s5;
    det2_s6 <= det2_s5;
    c2x_s6  <= c2x_s5;
    c2y_s6  <= c2y_s5;
    beat_s6 <= beat_s5;
  end

  // Stage 7: magnitudes and signs.
  logic signed [DET_W-1:0] det_sel;
  logic signed [MIN_W-1:0] cof_sel [3];
  logic [DET_W-1:0] mag_s7;
  logic [MIN_W-1:0] acof_s7 [3];
  logic [2:0]       neg_s7;
  logic             degen_s7;
  beat_t beat_s7;

  always_comb begin
    det_sel = beat_s6.tet ? det3_s6 : DET_W'(det2_s6);
    cof_sel[0] = beat_s6.tet ? cof_s6[0] : MIN_W'(c2x_s6);
    cof_sel[1] = beat_s6.tet ? cof_s6[1] : MIN_W'(c2y_s6);
    cof_sel[2] = beat_s6.tet ? cof_s6[2] : '0;
  end

  always_ff @(posedge clk) begin
    mag_s7   <= det_sel[DET_W-1] ? DET_W'(-det_sel) : DET_W'(det_sel);
    degen_s7 <= (det_sel == '0);
    for (int j = 0; j < 3; j++) begin
      acof_s7[j] <= cof_sel[j][MIN_W-1] ? MIN_W'(-cof_sel[j]) : MIN_W'(cof_sel[j]);
      neg_s7[j]  <= cof_sel[j][MIN_W-1];
    end
    beat_s7 <= beat_s6;
  end

  // Stage 8: overflow test, divider operands and the scaled determinant.
  logic [DET_W-1:0] mag_sh;
  logic             mag_big;
  logic [DET_W-1:0] num_s8 [3];
  logic [DET_W-1:0] mag_s8;
  logic [2:0]       sat_c;
  side_t            side_s8;

  always_comb begin
    mag_sh  = beat_s7.tet ? (mag_s7 >> FRAC_TET) : (mag_s7 >> FRAC_TRI);
    mag_big = |mag_sh[DET_W-1:ABS_DET_W];
    for (int j = 0; j < 3; j++) begin
      sat_c[j] = DET_W'(acof_s7[j]) >= mag_s7;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      num_s8[j] <= sat_c[j] ? '0 : DET_W'(acof_s7[j]);
    end
    mag_s8         <= mag_s7;
    side_s8.beat   <= beat_s7;
    side_s8.degen  <= degen_s7;
    side_s8.sat    <= sat_c;
    side_s8.neg    <= neg_s7;
    side_s8.absdet <= mag_big ? {ABS_DET_W{1'b1}} : mag_sh[ABS_DET_W-1:0];
  end

  // Dividers, one per gradient component.
  logic [GRAD_W-1:0] quo [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    seg_div_pipe #(
      .DEN_W (DET_W),
      .Q_W   (GRAD_W)
    ) u_div (
      .clk (clk),
      .num (num_s8[j]),
      .den (mag_s8),
      .quo (quo[j])
    );
  end

  side_t             side_q [GRAD_W];
  logic [GRAD_W-1:0] dvld;

  always_ff @(posedge clk) begin
    side_q[0] <= side_s8;
    for (int k = 1; k < GRAD_W; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      dvld  <= '0;
      valid <= 1'b0;
    end else begin
      vld   <= {vld[7:1], active};
      dvld  <= {dvld[GRAD_W-2:0], vld[8]};
      valid <= dvld[GRAD_W-1];
    end
  end

  function automatic logic [GRAD_W-1:0] finish(logic [GRAD_W-1:0] q, logic sat,
                                                logic neg, logic degen);
    logic [GRAD_W-1:0] r;
    if (degen) begin
      r = '0;
    end else if (sat) begin
      r = neg ? GRAD_MIN : GRAD_MAX;
    end else if (neg) begin
      r = q[GRAD_W-1] ? GRAD_MIN : GRAD_W'(-q);
    end else begin
      r = q[GRAD_W-1] ? GRAD_MAX : q;
    end
    return r;
  endfunction

  side_t side_o;
  assign side_o = side_q[GRAD_W-1];

  always_ff @(posedge clk) begin
    node_index <= side_o.beat.node;
    last_node  <= side_o.beat.last;
    degenerate <= side_o.degen;
    abs_det    <= side_o.degen ? '0 : side_o.absdet;
    grad_x     <= finish(quo[0], side_o.sat[0], side_o.neg[0], side_o.degen);
    grad_y     <= finish(quo[1], side_o.sat[1], side_o.neg[1], side_o.degen);
    grad_z     <= finish(quo[2], side_o.sat[2], side_o.neg[2], side_o.degen);
  end

  // An element's results leave back to back until the last one.
  a_nodes_contiguous: assert property (@(posedge clk) disable iff (rst)
    valid && !last_node |=> valid)
    else $error("node results of one element are not contiguous");

  // An item with an unsupported dimension starts no issue.
  a_bad_dim_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && dimension != DIM_TRI && dimension != DIM_TET |=> !busy)
    else $error("unsupported dimension started an element");

  // A degenerate element reports zero gradients and a zero determinant.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    valid && degenerate |-> grad_x == '0 && grad_y == '0 && grad_z == '0 && abs_det == '0)
    else $error("degenerate element with nonzero outputs");

endmodule
